FILE: rtl/core/sdt_pkg.sv
`default_nettype none

package sdt_pkg;

  localparam int FRAC = 30;        // fraction bits of the internal Q2.30 format
  localparam int ANG_W = 16;
  localparam int MAG_W = 15;       // clamped angle magnitude, at most 180 * 128
  localparam int RAD_W = 25;
  localparam int XM_W = 32;        // radians, Q2.30, at most pi
  localparam int X2_W = 34;        // x squared, at most pi^2
  localparam int COEF_W = 28;
  localparam int F_W = 32;         // x^2 / ((2k)(2k+1)), below 2.0
  localparam int TERM_W = 34;      // term magnitude, peaks near 5.2
  localparam int ACC_W = 36;       // signed running sum
  localparam int OUT_W = 16;
  localparam int MAX_K = 20;

  localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 16'sd23040;
  localparam logic [RAD_W-1:0] RAD_PER_DEG = 25'd18740330;
  localparam logic [63:0] HALF_Q30 = 64'd1 << (FRAC - 1);
  localparam logic [XM_W-1:0] XM_MAX = 32'd3373259400;

  // round(2^30 / ((2k)(2k+1))), k = 1 .. 19; both ends unused
  localparam logic [COEF_W-1:0] COEF_TABLE [0:MAX_K] = '{
    28'd0,
    28'd178956971, 28'd53687091, 28'd25565282, 28'd14913081, 28'd9761289,
    28'd6882960,   28'd5113056,  28'd3947580,  28'd3139596,  28'd2556528,
    28'd2122019,   28'd1789570,  28'd1529547,  28'd1322342,  28'd1154561,
    28'd1016801,   28'd902304,   28'd806112,   28'd724522,
    28'd0
  };

  typedef struct packed {
    logic [TERM_W-1:0]       term;  // magnitude of the term not yet summed
    logic [F_W-1:0]          f;     // factor that makes the next term
    logic [X2_W-1:0]         x2;
    logic signed [ACC_W-1:0] acc;   // sum of all earlier terms
    logic                    neg;   // sign of the angle
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/core/sdt_term_stage.sv
`default_nettype none

module sdt_term_stage import sdt_pkg::*; #(
  parameter logic [COEF_W-1:0] COEF = 28'd0,
  parameter bit ODD = 1'b0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   up_valid,
  input  wire stage_t up_data,
  output logic        up_ready,
  output logic        down_valid,
  output stage_t      down_data,
  input  wire logic   down_ready
);

  logic [TERM_W+F_W-1:0]   tprod;
  logic [X2_W+COEF_W-1:0]  fprod;
  logic signed [ACC_W-1:0] tsgn;
  logic                    tneg;
  stage_t                  nxt;

  // Advance the term and prepare the factor for the following stage.
  assign tprod = (TERM_W+F_W)'(up_data.term) * (TERM_W+F_W)'(up_data.f)
               + (TERM_W+F_W)'(HALF_Q30);
  assign fprod = (X2_W+COEF_W)'(up_data.x2) * (X2_W+COEF_W)'(COEF)
               + (X2_W+COEF_W)'(HALF_Q30);
  assign tneg = up_data.neg ^ ODD;
  assign tsgn = $signed({{(ACC_W-TERM_W){1'b0}}, up_data.term});

  always_comb begin
    nxt.term = tprod[FRAC+TERM_W-1:FRAC];
    nxt.f = fprod[FRAC+F_W-1:FRAC];
    nxt.x2 = up_data.x2;
    nxt.acc = tneg ? up_data.acc - tsgn : up_data.acc + tsgn;
    nxt.neg = up_data.neg;
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_data <= nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sine_degrees_taylor.sv
`default_nettype none

// Sine of an angle in degrees by a Taylor series, fully pipelined.
//
// Input channel: angle_deg, signed degrees with 7 fraction bits, taken when
// in_valid and in_ready are both high. Angles beyond +/-180 degrees clamp.
// Output channel: sine_value, Q1.15, delivered when out_valid and out_ready
// are both high. +1.0 saturates to 32767.
//
// Stages, in order: clamp, degree to radian multiply, squaring, first
// factor, one stage per further series term, final sum, magnitude, round
// and saturate. Throughput is one request per cycle while out_ready stays
// high; each term stage holds two multipliers (next term and next factor),
// every other stage at most one.
//
// Every stage has its own valid bit and takes a new request whenever it is
// empty or its successor moves, so bubbles collapse and in_ready can stay
// high while a finished result waits on out_ready. When the receiver
// stalls, the pipeline fills and then in_ready drops; nothing is lost or
// repeated. Reset clears all valid bits; data registers are not reset.
module sine_degrees_taylor import sdt_pkg::*; #(
  parameter int TERM_COUNT = 15
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [ANG_W-1:0] angle_deg,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      sine_value
);

  localparam int STAGES = TERM_COUNT - 1;
  localparam bit LAST_ODD = ((TERM_COUNT - 1) % 2) == 1;

  // Clamp stage
  logic                    v0, r0;
  logic [MAG_W-1:0]        mag0;
  logic                    neg0;
  logic signed [ANG_W-1:0] clamped;
  logic [ANG_W-1:0]        clamped_abs;

  // Radian stage
  logic                    v1, r1;
  logic [XM_W-1:0]         xm1;
  logic                    neg1;
  logic [MAG_W+RAD_W-1:0]  rprod;

  // Squaring stage
  logic                    v2, r2;
  logic [XM_W-1:0]         xm2;
  logic [X2_W-1:0]         x22;
  logic                    neg2;
  logic [2*XM_W:0]         xsq;

  // Series stages: entry 0 is loaded here, the rest by the term stages
  logic [STAGES:0]         tvld;
  stage_t                  tdat [0:STAGES];
  logic                    trdy [0:STAGES+1];
  logic [X2_W+COEF_W-1:0]  f1prod;

  // Final sum, magnitude and output stages
  logic                    vsum, rsum;
  logic signed [ACC_W-1:0] accf;
  logic signed [ACC_W-1:0] lterm;
  logic                    lneg;
  logic                    vmag, rmag;
  logic                    msneg;
  logic [ACC_W-1:0]        msmag;
  logic                    rout;
  logic [ACC_W-1:0]        qsum;
  logic [ACC_W-16:0]       q;
  logic [OUT_W-1:0]        qsat;

  // Clamp the angle and split it into sign and magnitude.
  always_comb begin
    if (angle_deg > ANGLE_LIMIT) begin
      clamped = ANGLE_LIMIT;
    end else if (angle_deg < -ANGLE_LIMIT) begin
      clamped = -ANGLE_LIMIT;
    end else begin
      clamped = angle_deg;
    end
    clamped_abs = clamped[ANG_W-1] ? ANG_W'(-clamped) : ANG_W'(clamped);
  end

  assign r0 = !v0 || r1;
  assign in_ready = r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (r0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && in_valid) begin
      mag0 <= clamped_abs[MAG_W-1:0];
      neg0 <= clamped[ANG_W-1];
    end
  end

  // Degrees with 7 fraction bits to Q2.30 radians, rounded.
  assign rprod = (MAG_W+RAD_W)'(mag0) * (MAG_W+RAD_W)'(RAD_PER_DEG)
               + (MAG_W+RAD_W)'(64);
  assign r1 = !v1 || r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && v0) begin
      xm1 <= rprod[XM_W+6:7];
      neg1 <= neg0;
    end
  end

  // Square the radian magnitude.
  assign xsq = (2*XM_W+1)'(xm1) * (2*XM_W+1)'(xm1) + (2*XM_W+1)'(HALF_Q30);
  assign r2 = !v2 || trdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      xm2 <= xm1;
      x22 <= xsq[FRAC+X2_W-1:FRAC];
      neg2 <= neg1;
    end
  end

  // Seed the series: first term is x, sum empty, factor for the second term.
  assign f1prod = (X2_W+COEF_W)'(x22) * (X2_W+COEF_W)'(COEF_TABLE[1])
                + (X2_W+COEF_W)'(HALF_Q30);
  assign trdy[0] = !tvld[0] || trdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tvld[0] <= 1'b0;
    end else if (trdy[0]) begin
      tvld[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (trdy[0] && v2) begin
      tdat[0].term <= TERM_W'(xm2);
      tdat[0].f <= f1prod[FRAC+F_W-1:FRAC];
      tdat[0].x2 <= x22;
      tdat[0].acc <= '0;
      tdat[0].neg <= neg2;
    end
  end

  // One stage per further term; stage j sums term j and forms term j+1.
  for (genvar j = 0; j < STAGES; j++) begin : g_term
    localparam int KN = (j + 2 < TERM_COUNT) ? j + 2 : 0;

    sdt_term_stage #(
      .COEF (COEF_TABLE[KN]),
      .ODD  ((j % 2) == 1)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (tvld[j]),
      .up_data    (tdat[j]),
      .up_ready   (trdy[j+1]),
      .down_valid (tvld[j+1]),
      .down_data  (tdat[j+1]),
      .down_ready (trdy[j+2])
    );
  end

  assign trdy[STAGES+1] = rsum;

  // Add the last term.
  assign lneg = tdat[STAGES].neg ^ LAST_ODD;
  assign lterm = $signed({{(ACC_W-TERM_W){1'b0}}, tdat[STAGES].term});
  assign rsum = !vsum || rmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vsum <= 1'b0;
    end else if (rsum) begin
      vsum <= tvld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rsum && tvld[STAGES]) begin
      accf <= lneg ? tdat[STAGES].acc - lterm : tdat[STAGES].acc + lterm;
    end
  end

  // Split the sum into sign and magnitude.
  assign rmag = !vmag || rout;

  always_ff @(posedge clk) begin
    if (rst) begin
      vmag <= 1'b0;
    end else if (rmag) begin
      vmag <= vsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rmag && vsum) begin
      msneg <= accf[ACC_W-1];
      msmag <= accf[ACC_W-1] ? ACC_W'(-accf) : ACC_W'(accf);
    end
  end

  // Round half away from zero to Q1.15, saturate, restore the sign.
  assign qsum = msmag + ACC_W'(16384);
  assign q = qsum[ACC_W-1:15];

  always_comb begin
    if (!msneg && q > (ACC_W-15)'(32767)) begin
      qsat = 16'd32767;
    end else if (msneg && q > (ACC_W-15)'(32768)) begin
      qsat = 16'd32768;
    end else begin
      qsat = q[OUT_W-1:0];
    end
  end

  assign rout = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rout) begin
      out_valid <= vmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rout && vmag) begin
      sine_value <= msneg ? $signed(OUT_W'(~qsat + 16'd1)) : $signed(qsat);
    end
  end

  // A clamped angle never yields more than pi radians.
  assert property (@(posedge clk) disable iff (rst) v1 |-> xm1 <= XM_MAX)
    else $error("radian magnitude above pi");

  // A full pipeline facing a stalled receiver must refuse new requests.
  assert property (@(posedge clk) disable iff (rst)
    (v0 && v1 && v2 && (&tvld) && vsum && vmag && out_valid && !out_ready)
      |-> !in_ready)
    else $error("request accepted into a full stalled pipeline");

  // A non-negative sum never produces a negative sine.
  assert property (@(posedge clk) disable iff (rst)
    (vmag && rout && !msneg) |=> !sine_value[OUT_W-1])
    else $error("sign flipped in output rounding");

  // An empty clamp stage always accepts a request.
  assert property (@(posedge clk) disable iff (rst) !v0 |-> in_ready)
    else $error("input blocked with an empty front stage");

endmodule

`default_nettype wire
